>>> src/hprm_pkg.sv
// Package for the heartbeat peak rate meter: sizes, constants, register indexes, types.
`default_nettype none
package hprm_pkg;

  // Default widths of the sample and of the period counter
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned PERIOD_BITS = 20;

  // Fixed field widths
  localparam int unsigned INTERVAL_BITS  = 10;
  localparam int unsigned BAR_BITS       = 6;
  localparam int unsigned BPM_BITS       = 10;
  localparam int unsigned CFG_INDEX_BITS = 1;

  // Register reset values
  localparam int unsigned THRESHOLD_RESET = 2560;
  localparam int unsigned INTERVAL_RESET  = 25;

  // Rate arithmetic
  localparam int unsigned MS_PER_MINUTE     = 60000;
  localparam int unsigned RATE_LIMIT        = 999;
  localparam int unsigned DIVIDEND_BITS     = $clog2(MS_PER_MINUTE + 1);
  localparam int unsigned DIV_CNT_BITS      = $clog2(DIVIDEND_BITS);
  // Periods at or below this give a rate of RATE_LIMIT or more (or no rate at all)
  localparam int unsigned RATE_FLOOR_PERIOD = MS_PER_MINUTE / RATE_LIMIT;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_THRESHOLD     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_INTERVAL_MS = 1'b1;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

>>> src/hprm_if.sv
// Channel interfaces of the heartbeat peak rate meter: sample input and result output.
`default_nettype none
interface hprm_in_if #(
  parameter int unsigned SampleBits = hprm_pkg::SAMPLE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hprm_out_if;
  import hprm_pkg::*;

  logic                valid;
  logic                ready;
  logic [BAR_BITS-1:0] bar_level;
  logic                beat_detected;
  logic                rate_valid;
  logic [BPM_BITS-1:0] beats_per_minute;

  modport source (output valid, output bar_level, output beat_detected,
                  output rate_valid, output beats_per_minute, input ready);
  modport sink   (input valid, input bar_level, input beat_detected,
                  input rate_valid, input beats_per_minute, output ready);
endinterface
`default_nettype wire

>>> src/hprm_front.sv
// Front end: accepts samples, detects peaks, tracks the beat period, builds jobs.
`default_nettype none
module hprm_front #(
  parameter int unsigned SampleBits = hprm_pkg::SAMPLE_BITS,
  parameter int unsigned PeriodBits = hprm_pkg::PERIOD_BITS,
  localparam int unsigned JobW      = PeriodBits + hprm_pkg::BAR_BITS + 1
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  hprm_in_if.sink                               in_ch,
  input  wire [SampleBits-1:0]                  peak_threshold,
  input  wire [hprm_pkg::INTERVAL_BITS-1:0]     sample_interval_ms,
  output logic                                  push_valid,
  input  wire                                   push_ready,
  output logic [JobW-1:0]                       push_data
);
  import hprm_pkg::*;

  logic [SampleBits-1:0] prev_r, prev_nxt;
  logic                  rising_r, rising_nxt;
  logic [PeriodBits-1:0] elapsed_r, elapsed_nxt;

  logic                  accept;
  logic                  rising;
  logic                  beat;
  logic [SampleBits+1:0] times3;
  logic [BAR_BITS-1:0]   bar;
  logic [PeriodBits-1:0] base;
  logic [PeriodBits:0]   sum;

  assign push_valid   = in_ch.valid;
  assign in_ch.ready  = push_ready;
  assign accept       = in_ch.valid & push_ready;

  // Classify the sample against the previous one and the threshold
  assign rising = (prev_r <= in_ch.sample);
  assign beat   = (in_ch.sample >= peak_threshold) & rising_r & ~rising;

  // Bar level: sample*48 >> SampleBits, done as (sample*3) >> (SampleBits-4)
  assign times3 = {2'b00, in_ch.sample} + {1'b0, in_ch.sample, 1'b0};
  assign bar    = times3[SampleBits+1 -: BAR_BITS];

  // Restart the period on a beat, then add the interval with saturation
  assign base = beat ? '0 : elapsed_r;
  assign sum  = {1'b0, base} + (PeriodBits+1)'(sample_interval_ms);

  assign push_data = {bar, beat, elapsed_r};

  always_comb begin
    prev_nxt    = prev_r;
    rising_nxt  = rising_r;
    elapsed_nxt = elapsed_r;
    if (accept) begin
      prev_nxt    = in_ch.sample;
      rising_nxt  = rising;
      elapsed_nxt = sum[PeriodBits] ? '1 : sum[PeriodBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      rising_r  <= 1'b0;
      elapsed_r <= '0;
    end else begin
      prev_r    <= prev_nxt;
      rising_r  <= rising_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/hprm_queue.sv
// Two-entry job queue between the front end and the back end.
`default_nettype none
module hprm_queue #(
  parameter int unsigned Width = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire [Width-1:0]  push_data,
  output logic             pop_valid,
  input  wire              pop,
  output logic [Width-1:0] pop_data
);
  localparam int unsigned Depth = 2;

  logic [Width-1:0] entry_r [Depth];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != 2'(Depth));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> src/hprm_back.sv
// Back end: serial division of 60000 by the period and the output register.
`default_nettype none
module hprm_back #(
  parameter int unsigned PeriodBits = hprm_pkg::PERIOD_BITS,
  localparam int unsigned JobW      = PeriodBits + hprm_pkg::BAR_BITS + 1
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  output logic             pop,
  input  wire [JobW-1:0]   q_data,
  hprm_out_if.source       out_ch
);
  import hprm_pkg::*;

  localparam logic [DIVIDEND_BITS-1:0] Dividend = DIVIDEND_BITS'(MS_PER_MINUTE);
  localparam logic [PeriodBits-1:0]    FloorPeriod = PeriodBits'(RATE_FLOOR_PERIOD);
  localparam logic [DIV_CNT_BITS-1:0]  CntOne = DIV_CNT_BITS'(1);

  back_state_t               state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [PeriodBits-1:0]     divisor_r, divisor_nxt;
  logic [PeriodBits-1:0]     rem_r, rem_nxt;
  logic [DIVIDEND_BITS-1:0]  quot_r, quot_nxt;
  logic [BAR_BITS-1:0]       bar_hold_r, bar_hold_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [BAR_BITS-1:0]       bar_r, bar_nxt;
  logic                      beat_r, beat_nxt;
  logic                      rate_valid_r, rate_valid_nxt;
  logic [BPM_BITS-1:0]       bpm_r, bpm_nxt;

  logic [PeriodBits-1:0]     q_period;
  logic                      q_beat;
  logic [BAR_BITS-1:0]       q_bar;
  logic                      out_free;
  logic [PeriodBits:0]       rem_sh;
  logic [PeriodBits:0]       rem_sub;
  logic                      ge;

  assign q_period = q_data[PeriodBits-1:0];
  assign q_beat   = q_data[PeriodBits];
  assign q_bar    = q_data[PeriodBits+BAR_BITS -: BAR_BITS];
  assign out_free = ~out_valid_r | out_ch.ready;

  // One restoring division step: shift in the next dividend bit, try to subtract
  assign rem_sh  = {rem_r, Dividend[cnt_r]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  assign ge      = (rem_sh >= {1'b0, divisor_r});

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    divisor_nxt    = divisor_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    bar_hold_nxt   = bar_hold_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    bar_nxt        = bar_r;
    beat_nxt       = beat_r;
    rate_valid_nxt = rate_valid_r;
    bpm_nxt        = bpm_r;
    pop            = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          if (q_beat && (q_period > FloorPeriod)) begin
            // Start the division; the rate fits below the limit
            state_nxt    = BK_DIV;
            cnt_nxt      = DIV_CNT_BITS'(DIVIDEND_BITS - 1);
            divisor_nxt  = q_period;
            rem_nxt      = '0;
            quot_nxt     = '0;
            bar_hold_nxt = q_bar;
          end else begin
            // No beat, or a rate out of range: report without dividing
            out_valid_nxt  = 1'b1;
            bar_nxt        = q_bar;
            beat_nxt       = q_beat;
            rate_valid_nxt = 1'b0;
            bpm_nxt        = '0;
          end
        end
      end
      BK_DIV: begin
        rem_nxt  = ge ? rem_sub[PeriodBits-1:0] : rem_sh[PeriodBits-1:0];
        quot_nxt = {quot_r[DIVIDEND_BITS-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = BK_DONE;
        end else begin
          cnt_nxt = cnt_r - CntOne;
        end
      end
      BK_DONE: begin
        // Hold the quotient until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          bar_nxt        = bar_hold_r;
          beat_nxt       = 1'b1;
          rate_valid_nxt = 1'b1;
          bpm_nxt        = quot_r[BPM_BITS-1:0];
          state_nxt      = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    divisor_r    <= divisor_nxt;
    rem_r        <= rem_nxt;
    quot_r       <= quot_nxt;
    bar_hold_r   <= bar_hold_nxt;
    bar_r        <= bar_nxt;
    beat_r       <= beat_nxt;
    rate_valid_r <= rate_valid_nxt;
    bpm_r        <= bpm_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.bar_level        = bar_r;
  assign out_ch.beat_detected    = beat_r;
  assign out_ch.rate_valid       = rate_valid_r;
  assign out_ch.beats_per_minute = bpm_r;

`ifndef SYNTHESIS
  a_rate_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rate_valid_r) |-> beat_r)
    else $error("rate reported without a beat");

  a_bpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !rate_valid_r) |-> (bpm_r == '0))
    else $error("nonzero rate without rate_valid");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && cnt_r != '0) |=>
      (state_r == BK_DIV && cnt_r == $past(cnt_r) - CntOne))
    else $error("division step count skipped");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && cnt_r == '0) |=> (state_r == BK_DONE))
    else $error("division did not finish after the last step");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == BK_IDLE && q_valid && out_free))
    else $error("job taken while busy");
`endif

endmodule
`default_nettype wire

>>> src/heartbeat_peak_rate_meter.sv
// Top level of the heartbeat peak rate meter: configuration registers and block wiring.
`default_nettype none
// One result item per sample item. The front end takes a sample every cycle while
// the two-entry job queue has room. In the back end a sample without a beat, or a
// beat whose period is 60 ms or less (rate of 999 or more, or no period), passes
// to the output register; a beat with a longer period runs a restoring divider
// of 60000 by the period at one quotient bit per cycle and holds the back end
// until the quotient is in the output register. The back end takes the next job
// only when the output register is empty or being taken in that cycle, so a result
// that waits stalls it and, once the queue is full, the input. Configuration writes
// take effect at the next clock edge and should be made only while the block is idle.
module heartbeat_peak_rate_meter #(
  parameter int unsigned SampleBits = hprm_pkg::SAMPLE_BITS,
  parameter int unsigned PeriodBits = hprm_pkg::PERIOD_BITS,
  localparam int unsigned CfgDataW  = (SampleBits > hprm_pkg::INTERVAL_BITS) ?
                                      SampleBits : hprm_pkg::INTERVAL_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  hprm_in_if.sink                              in_ch,
  hprm_out_if.source                           out_ch,
  input  wire                                  cfg_we,
  input  wire [hprm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [CfgDataW-1:0]                   cfg_data
);
  import hprm_pkg::*;

  localparam int unsigned JobW = PeriodBits + BAR_BITS + 1;

  logic [SampleBits-1:0]    threshold_r, threshold_nxt;
  logic [INTERVAL_BITS-1:0] interval_r, interval_nxt;

  logic            push_valid;
  logic            push_ready;
  logic [JobW-1:0] push_data;
  logic            q_valid;
  logic            pop;
  logic [JobW-1:0] q_data;

  // Decode register writes
  always_comb begin
    threshold_nxt = threshold_r;
    interval_nxt  = interval_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_THRESHOLD:     threshold_nxt = cfg_data[SampleBits-1:0];
        REG_SAMPLE_INTERVAL_MS: interval_nxt  = cfg_data[INTERVAL_BITS-1:0];
        default: begin
          threshold_nxt = threshold_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= SampleBits'(THRESHOLD_RESET);
      interval_r  <= INTERVAL_BITS'(INTERVAL_RESET);
    end else begin
      threshold_r <= threshold_nxt;
      interval_r  <= interval_nxt;
    end
  end

  hprm_front #(
    .SampleBits (SampleBits),
    .PeriodBits (PeriodBits)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ch              (in_ch),
    .peak_threshold     (threshold_r),
    .sample_interval_ms (interval_r),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_data          (push_data)
  );

  hprm_queue #(
    .Width (JobW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (pop),
    .pop_data   (q_data)
  );

  hprm_back #(
    .PeriodBits (PeriodBits)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .pop     (pop),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
